[design/dhu_pkg.sv]
// Shared widths, codes, reset values and types for the dual hysteresis controller.
package dhu_pkg;

    localparam int ReqW   = 3;
    localparam int StateW = 3;
    localparam int ValW   = 15;
    localparam int HysW   = 10;
    localparam int HumW   = 14;
    localparam int IdxW   = 2;
    localparam int CmpW   = ValW + 1;

    // Request codes.
    localparam logic [ReqW-1:0] REQ_MEAS   = 3'd0;
    localparam logic [ReqW-1:0] REQ_OFF    = 3'd1;
    localparam logic [ReqW-1:0] REQ_ON     = 3'd2;
    localparam logic [ReqW-1:0] REQ_TOGGLE = 3'd3;
    localparam logic [ReqW-1:0] REQ_AUTO   = 3'd4;

    // State codes.
    localparam logic [StateW-1:0] ST_AUTO_OFF = 3'd0;
    localparam logic [StateW-1:0] ST_AUTO_ON  = 3'd1;
    localparam logic [StateW-1:0] ST_MAN_OFF  = 3'd2;
    localparam logic [StateW-1:0] ST_MAN_ON   = 3'd3;
    localparam logic [StateW-1:0] ST_UNKNOWN  = 3'd4;

    // Configuration register indexes.
    localparam logic [IdxW-1:0] CFG_TEMP_THR = 2'd0;
    localparam logic [IdxW-1:0] CFG_TEMP_HYS = 2'd1;
    localparam logic [IdxW-1:0] CFG_HUM_THR  = 2'd2;
    localparam logic [IdxW-1:0] CFG_HUM_HYS  = 2'd3;

    // Saturation limits and reset values.
    localparam logic signed [ValW-1:0] VAL_LO      = -15'sd4000;
    localparam logic signed [ValW-1:0] VAL_HI      = 15'sd10000;
    localparam logic signed [ValW-1:0] TEMP_THR_HI = 15'sd8500;
    localparam logic [HumW-1:0]        HUM_THR_HI  = 14'd10000;
    localparam logic [HysW-1:0]        HYS_HI      = 10'd1000;

    localparam logic signed [ValW-1:0] TEMP_THR_RST = 15'sd2500;
    localparam logic [HysW-1:0]        TEMP_HYS_RST = 10'd50;
    localparam logic signed [ValW-1:0] HUM_THR_RST  = 15'sd2000;
    localparam logic [HysW-1:0]        HUM_HYS_RST  = 10'd100;
    localparam logic signed [ValW-1:0] LAST_RST     = 15'sd10000;

    typedef struct packed {
        logic signed [ValW-1:0] temp_thr;
        logic [HysW-1:0]        temp_hys;
        logic signed [ValW-1:0] hum_thr;
        logic [HysW-1:0]        hum_hys;
    } t_cfg;

endpackage

[design/dhu_cfg.sv]
// Configuration registers, saturated to their legal ranges as they are written.
module dhu_cfg
    import dhu_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  logic [IdxW-1:0] i_index,
    input  logic [ValW-1:0] i_data,
    output t_cfg            o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    logic signed [ValW-1:0] w_temp_thr;
    logic [HumW-1:0]        w_hum_thr;
    logic [HysW-1:0]        w_hys;

    always_comb begin
        w_temp_thr = signed'(i_data);
        w_hum_thr  = i_data[HumW-1:0];
        w_hys      = i_data[HysW-1:0];
        n_cfg      = r_cfg;
        case (i_index)
            CFG_TEMP_THR: begin
                if (w_temp_thr < VAL_LO) begin
                    n_cfg.temp_thr = VAL_LO;
                end else if (w_temp_thr > TEMP_THR_HI) begin
                    n_cfg.temp_thr = TEMP_THR_HI;
                end else begin
                    n_cfg.temp_thr = w_temp_thr;
                end
            end
            CFG_TEMP_HYS: begin
                n_cfg.temp_hys = (w_hys > HYS_HI) ? HYS_HI : w_hys;
            end
            CFG_HUM_THR: begin
                n_cfg.hum_thr = signed'({1'b0, (w_hum_thr > HUM_THR_HI) ? HUM_THR_HI
                                                                        : w_hum_thr});
            end
            CFG_HUM_HYS: begin
                n_cfg.hum_hys = (w_hys > HYS_HI) ? HYS_HI : w_hys;
            end
            default: begin
                n_cfg = r_cfg;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.temp_thr <= TEMP_THR_RST;
            r_cfg.temp_hys <= TEMP_HYS_RST;
            r_cfg.hum_thr  <= HUM_THR_RST;
            r_cfg.hum_hys  <= HUM_HYS_RST;
        end else if (i_wr) begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[design/dhu_core.sv]
// Channel state, hysteresis rule and result register.
module dhu_core
    import dhu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_item_valid,
    input  logic [ReqW-1:0]   i_req_type,
    input  logic              i_channel,
    input  logic [ValW-1:0]   i_value,
    output logic              o_advance,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_out_channel,
    output logic [StateW-1:0] o_state_code,
    output logic              o_drive_level
);

    logic [StateW-1:0]      r_state [2];
    logic                   r_drive [2];
    logic signed [ValW-1:0] r_last  [2];

    logic              r_out_valid;
    logic              r_out_channel;
    logic [StateW-1:0] r_out_state;
    logic              r_out_drive;

    logic [StateW-1:0]      w_old;
    logic                   w_drv;
    logic signed [ValW-1:0] w_last;
    logic signed [ValW-1:0] w_val;
    logic signed [ValW-1:0] w_thr;
    logic [HysW-1:0]        w_hys;
    logic signed [CmpW-1:0] w_cmp;
    logic signed [CmpW-1:0] w_lo;
    logic signed [CmpW-1:0] w_hi;
    logic                   w_manual;
    logic                   w_below;
    logic                   w_above;
    logic [StateW-1:0]      n_state;
    logic                   n_drive;
    logic signed [ValW-1:0] n_last;

    // The result register is free this cycle or is being emptied.
    assign o_advance = !r_out_valid || i_out_ready;

    always_comb begin
        w_old    = r_state[i_channel];
        w_drv    = r_drive[i_channel];
        w_last   = r_last[i_channel];
        w_thr    = i_channel ? i_cfg.hum_thr : i_cfg.temp_thr;
        w_hys    = i_channel ? i_cfg.hum_hys : i_cfg.temp_hys;
        w_manual = (w_old == ST_MAN_OFF) || (w_old == ST_MAN_ON);

        if (signed'(i_value) < VAL_LO) begin
            w_val = VAL_LO;
        end else if (signed'(i_value) > VAL_HI) begin
            w_val = VAL_HI;
        end else begin
            w_val = signed'(i_value);
        end

        // A measurement tests its own value; the auto command tests the stored one.
        w_cmp   = (i_req_type == REQ_MEAS) ? CmpW'(w_val) : CmpW'(w_last);
        w_lo    = CmpW'(w_thr) - signed'(CmpW'(w_hys));
        w_hi    = CmpW'(w_thr) + signed'(CmpW'(w_hys));
        w_below = w_cmp < w_lo;
        w_above = w_cmp > w_hi;

        n_state = w_old;
        n_drive = w_drv;
        n_last  = w_last;
        case (i_req_type)
            REQ_MEAS, REQ_AUTO: begin
                if (!(i_req_type == REQ_MEAS && w_manual)) begin
                    if (i_req_type == REQ_MEAS) begin
                        n_last = w_val;
                    end
                    if (w_below) begin
                        n_state = ST_AUTO_ON;
                        n_drive = 1'b1;
                    end else if (w_above) begin
                        n_state = ST_AUTO_OFF;
                        n_drive = 1'b0;
                    end else if (w_manual) begin
                        n_state = w_drv ? ST_AUTO_ON : ST_AUTO_OFF;
                    end
                end
            end
            REQ_OFF: begin
                n_state = ST_MAN_OFF;
                n_drive = 1'b0;
            end
            REQ_ON: begin
                n_state = ST_MAN_ON;
                n_drive = 1'b1;
            end
            REQ_TOGGLE: begin
                if (w_old == ST_AUTO_OFF || w_old == ST_MAN_OFF ||
                    (w_old == ST_UNKNOWN && !w_drv)) begin
                    n_state = ST_MAN_ON;
                    n_drive = 1'b1;
                end else begin
                    n_state = ST_MAN_OFF;
                    n_drive = 1'b0;
                end
            end
            default: begin
                n_state = w_old;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state[0] <= ST_UNKNOWN;
            r_state[1] <= ST_UNKNOWN;
            r_drive[0] <= 1'b0;
            r_drive[1] <= 1'b0;
            r_last[0]  <= LAST_RST;
            r_last[1]  <= LAST_RST;
        end else if (i_item_valid && o_advance) begin
            r_state[i_channel] <= n_state;
            r_drive[i_channel] <= n_drive;
            r_last[i_channel]  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_advance) begin
            r_out_valid <= i_item_valid && (n_state != w_old);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_item_valid) begin
            r_out_channel <= i_channel;
            r_out_state   <= n_state;
            r_out_drive   <= n_drive;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_channel = r_out_channel;
    assign o_state_code  = r_out_state;
    assign o_drive_level = r_out_drive;

endmodule

[design/dual_hysteresis_unit_control_top.sv]
// Dual hysteresis controller: input register, channel core and configuration registers.
// An accepted item passes the input register, then the result register; an item that
// changes no state code shows nothing.
// Throughput: one item per cycle; the input stalls only while a result waits for the receiver.
// Reset (synchronous, active low): both channels unknown with drive off, last readings
// 100.00, thresholds and bands at their defaults, no item or result pending.
module dual_hysteresis_unit_control_top
    import dhu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [ReqW-1:0]   i_req_type,
    input  logic              i_channel,
    input  logic [ValW-1:0]   i_value,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_out_channel,
    output logic [StateW-1:0] o_state_code,
    output logic              o_drive_level,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [IdxW-1:0]   i_cfg_index,
    input  logic [ValW-1:0]   i_cfg_data
);

    logic            r_in_valid;
    logic [ReqW-1:0] r_req_type;
    logic            r_channel;
    logic [ValW-1:0] r_value;
    logic            w_advance;
    t_cfg            w_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_req_type <= i_req_type;
            r_channel  <= i_channel;
            r_value    <= i_value;
        end
    end

    dhu_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    dhu_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_item_valid  (r_in_valid),
        .i_req_type    (r_req_type),
        .i_channel     (r_channel),
        .i_value       (r_value),
        .o_advance     (w_advance),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_channel (o_out_channel),
        .o_state_code  (o_state_code),
        .o_drive_level (o_drive_level)
    );

endmodule

[sim/dual_hysteresis_unit_control_top_tb.sv]
// Self-checking testbench for the dual hysteresis controller top level.
module dual_hysteresis_unit_control_top_tb;
    import dhu_pkg::*;

    localparam int          RESET_CYCLES = 8;
    localparam int          DRAIN_CYCLES = 6;
    localparam int          CYCLE_LIMIT  = 300000;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          SEGMENTS     = 8;
    localparam int          SEGMENT_REQS = 225;
    localparam int          PRESSURE_REQS = 30;
    localparam logic [ReqW-1:0] REQ_UNUSED_LO = 3'd5;
    localparam logic [ReqW-1:0] REQ_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic              chan;
        logic [StateW-1:0] code;
        logic              drive;
    } chan_status_t;

    typedef struct {
        logic [ReqW-1:0] req;
        logic            chan;
        logic [ValW-1:0] val;
        bit              typed;
        bit              typed_has;
        chan_status_t    typed_status;
    } step_row_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [ReqW-1:0]   i_req_type;
    logic              i_channel;
    logic [ValW-1:0]   i_value;
    logic              o_out_valid;
    logic              i_out_ready;
    logic              o_out_channel;
    logic [StateW-1:0] o_state_code;
    logic              o_drive_level;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [IdxW-1:0]   i_cfg_index;
    logic [ValW-1:0]   i_cfg_data;

    dual_hysteresis_unit_control_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_channel     (i_channel),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_channel (o_out_channel),
        .o_state_code  (o_state_code),
        .o_drive_level (o_drive_level),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Mirror of the controller: settings and per-channel state.
    logic signed [ValW-1:0] temp_thr_reg;
    logic [HysW-1:0]        temp_hys_reg;
    logic [HumW-1:0]        hum_thr_reg;
    logic [HysW-1:0]        hum_hys_reg;
    logic [StateW-1:0]      chan_state [2];
    logic                   chan_drive [2];
    int                     chan_last  [2];

    chan_status_t pending_status [$];
    step_row_t    directed_steps [$];

    int unsigned idle_pct;
    int unsigned stall_pct;
    int          hold_reqs;
    int          hold_done;
    int          error_count;
    int          checked_count;
    int          accepted_count;
    int          settings_count;
    int          cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int clip(input int v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void get_band(input logic chan, output int thr, output int hys);
        if (chan) begin
            thr = clip(int'(hum_thr_reg), 0, int'(HUM_THR_HI));
            hys = clip(int'(hum_hys_reg), 0, int'(HYS_HI));
        end else begin
            thr = clip(int'(temp_thr_reg), int'(VAL_LO), int'(TEMP_THR_HI));
            hys = clip(int'(temp_hys_reg), 0, int'(HYS_HI));
        end
    endfunction

    function automatic void apply_band(input int reading, input int thr, input int hys,
                                       inout logic [StateW-1:0] st, inout logic drv);
        if (reading < thr - hys) begin
            st  = ST_AUTO_ON;
            drv = 1'b1;
        end else if (reading > thr + hys) begin
            st  = ST_AUTO_OFF;
            drv = 1'b0;
        end else if (st == ST_MAN_OFF || st == ST_MAN_ON) begin
            // Inside the band a manual channel goes back to auto with its drive held.
            st = drv ? ST_AUTO_ON : ST_AUTO_OFF;
        end
    endfunction

    // Updates the mirrored state and reports whether the state code changed.
    function automatic bit predict_request(input logic [ReqW-1:0] req, input logic chan,
                                           input logic [ValW-1:0] raw,
                                           output chan_status_t status);
        logic [StateW-1:0] st;
        logic [StateW-1:0] prior;
        logic              drv;
        int                thr;
        int                hys;
        int                reading;
        bit                acted;
        st      = chan_state[chan];
        prior   = st;
        drv     = chan_drive[chan];
        reading = clip(int'($signed(raw)), int'(VAL_LO), int'(VAL_HI));
        get_band(chan, thr, hys);
        acted   = 1'b1;
        case (req)
            REQ_MEAS: begin
                if (prior == ST_MAN_OFF || prior == ST_MAN_ON) begin
                    acted = 1'b0;
                end else begin
                    chan_last[chan] = reading;
                    apply_band(reading, thr, hys, st, drv);
                end
            end
            REQ_OFF: begin
                st  = ST_MAN_OFF;
                drv = 1'b0;
            end
            REQ_ON: begin
                st  = ST_MAN_ON;
                drv = 1'b1;
            end
            REQ_TOGGLE: begin
                if (prior == ST_AUTO_OFF || prior == ST_MAN_OFF
                        || (prior == ST_UNKNOWN && !drv)) begin
                    st  = ST_MAN_ON;
                    drv = 1'b1;
                end else begin
                    st  = ST_MAN_OFF;
                    drv = 1'b0;
                end
            end
            REQ_AUTO: begin
                apply_band(chan_last[chan], thr, hys, st, drv);
            end
            default: begin
                acted = 1'b0;
            end
        endcase
        chan_state[chan] = st;
        chan_drive[chan] = drv;
        status.chan  = chan;
        status.code  = st;
        status.drive = drv;
        return acted && (st != prior);
    endfunction

    function automatic void add_step(input logic [ReqW-1:0] req, input logic chan,
                                     input logic [ValW-1:0] val, input bit typed,
                                     input bit typed_has, input logic [StateW-1:0] code,
                                     input logic drive);
        step_row_t row;
        row.req                = req;
        row.chan               = chan;
        row.val                = val;
        row.typed              = typed;
        row.typed_has          = typed_has;
        row.typed_status.chan  = chan;
        row.typed_status.code  = code;
        row.typed_status.drive = drive;
        directed_steps.push_back(row);
    endfunction

    function automatic logic [ValW-1:0] pick_setting(input int lo, input int hi);
        int t;
        if ($urandom_range(9) < 7)
            t = lo + int'($urandom_range(hi - lo));
        else
            t = int'($urandom_range(32767));
        return t[ValW-1:0];
    endfunction

    // Mostly values around the switching band of the channel, some anywhere.
    function automatic void random_request(output logic [ReqW-1:0] req, output logic chan,
                                           output logic [ValW-1:0] val);
        int unsigned pick;
        int          thr;
        int          hys;
        int          span;
        int          v;
        chan = 1'($urandom_range(1));
        get_band(chan, thr, hys);
        pick = $urandom_range(99);
        if (pick < 55)      req = REQ_MEAS;
        else if (pick < 65) req = REQ_OFF;
        else if (pick < 75) req = REQ_ON;
        else if (pick < 85) req = REQ_TOGGLE;
        else if (pick < 95) req = REQ_AUTO;
        else                req = ReqW'($urandom_range(REQ_UNUSED_HI, REQ_UNUSED_LO));
        span = hys + 150;
        pick = $urandom_range(99);
        if (pick < 45) begin
            v = thr - span + int'($urandom_range(2 * span));
        end else if (pick < 65) begin
            case ($urandom_range(3))
                0:       v = thr - hys - 1;
                1:       v = thr - hys;
                2:       v = thr + hys;
                default: v = thr + hys + 1;
            endcase
        end else if (pick < 85) begin
            v = int'(VAL_LO) + int'($urandom_range(int'(VAL_HI) - int'(VAL_LO)));
        end else begin
            v = int'($urandom_range(32767));
        end
        val = v[ValW-1:0];
    endfunction

    task automatic offer_request(input logic [ReqW-1:0] req, input logic chan,
                                 input logic [ValW-1:0] val, input bit typed,
                                 input bit typed_has, input chan_status_t typed_status);
        bit           has;
        chan_status_t status;
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_channel  <= chan;
        i_value    <= val;
        do @(posedge i_clk); while (!o_in_ready);
        has = predict_request(req, chan, val, status);
        if (typed) begin
            has    = typed_has;
            status = typed_status;
        end
        if (has)
            pending_status.push_back(status);
        accepted_count++;
    endtask

    task automatic write_setting(input logic [IdxW-1:0] idx, input logic [ValW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_TEMP_THR: temp_thr_reg = data;
            CFG_TEMP_HYS: temp_hys_reg = data[HysW-1:0];
            CFG_HUM_THR:  hum_thr_reg  = data[HumW-1:0];
            default:      hum_hys_reg  = data[HysW-1:0];
        endcase
    endtask

    task automatic program_settings(input logic [ValW-1:0] temp_thr,
                                    input logic [ValW-1:0] temp_hys,
                                    input logic [ValW-1:0] hum_thr,
                                    input logic [ValW-1:0] hum_hys);
        write_setting(CFG_TEMP_THR, temp_thr);
        write_setting(CFG_TEMP_HYS, temp_hys);
        write_setting(CFG_HUM_THR, hum_thr);
        write_setting(CFG_HUM_HYS, hum_hys);
        i_cfg_valid <= 1'b0;
        settings_count++;
    endtask

    // Waits until every expected status change has arrived and the pipeline is empty.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Receiver side: random stalls, plus long hold-offs on request.
    initial begin
        int hold_left;
        hold_left   = 0;
        hold_done   = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0 && hold_done != hold_reqs) begin
                hold_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : watch_status
        chan_status_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_status.size() == 0) begin
                if (error_count < 10)
                    $display("unexpected status change: ch %0d code %0d drive %0d",
                             o_out_channel, o_state_code, o_drive_level);
                error_count++;
            end else begin
                want = pending_status.pop_front();
                checked_count++;
                if (o_out_channel !== want.chan || o_state_code !== want.code
                        || o_drive_level !== want.drive) begin
                    if (error_count < 10)
                        $display("status mismatch: expected ch %0d code %0d drive %0d, got ch %0d code %0d drive %0d",
                                 want.chan, want.code, want.drive,
                                 o_out_channel, o_state_code, o_drive_level);
                    error_count++;
                end
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("dual_hysteresis_unit_control_top_tb: FAIL");
        $finish;
    end

    initial begin
        int               seg;
        int               done;
        logic [ReqW-1:0]  req;
        logic             chan;
        logic [ValW-1:0]  val;
        chan_status_t     none;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_req_type  <= REQ_MEAS;
        i_channel   <= 1'b0;
        i_value     <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_TEMP_THR;
        i_cfg_data  <= '0;

        idle_pct       = 0;
        stall_pct      = 0;
        hold_reqs      = 0;
        error_count    = 0;
        checked_count  = 0;
        accepted_count = 0;
        settings_count = 0;
        none           = '0;
        temp_thr_reg   = TEMP_THR_RST;
        temp_hys_reg   = TEMP_HYS_RST;
        hum_thr_reg    = HUM_THR_RST[HumW-1:0];
        hum_hys_reg    = HUM_HYS_RST;
        for (int c = 0; c < 2; c++) begin
            chan_state[c] = ST_UNKNOWN;
            chan_drive[c] = 1'b0;
            chan_last[c]  = int'(LAST_RST);
        end

        // Default settings: heater band 24.50..25.50, humidifier band 19.00..21.00.
        add_step(REQ_AUTO,      1'b0, 15'd0,    1, 1, ST_AUTO_OFF, 1'b0);
        add_step(REQ_TOGGLE,    1'b1, 15'd0,    1, 1, ST_MAN_ON,   1'b1);
        add_step(REQ_MEAS,      1'b1, VAL_LO,   1, 0, ST_MAN_ON,   1'b1);
        add_step(REQ_MEAS,      1'b0, 15'h4000, 1, 1, ST_AUTO_ON,  1'b1);
        add_step(REQ_MEAS,      1'b0, 15'h3FFF, 1, 1, ST_AUTO_OFF, 1'b0);
        add_step(REQ_MEAS,      1'b0, 15'd2450, 0, 0, ST_AUTO_OFF, 1'b0);
        add_step(REQ_MEAS,      1'b0, 15'd2449, 0, 0, ST_AUTO_OFF, 1'b0);
        add_step(REQ_MEAS,      1'b0, 15'd2550, 0, 0, ST_AUTO_OFF, 1'b0);
        add_step(REQ_MEAS,      1'b0, 15'd2551, 0, 0, ST_AUTO_OFF, 1'b0);
        add_step(REQ_UNUSED_LO, 1'b0, 15'd0,    1, 0, ST_AUTO_OFF, 1'b0);
        add_step(REQ_UNUSED_HI, 1'b1, 15'h3FFF, 1, 0, ST_AUTO_OFF, 1'b0);
        add_step(REQ_OFF,       1'b0, 15'd0,    1, 1, ST_MAN_OFF,  1'b0);
        add_step(REQ_OFF,       1'b0, 15'd0,    1, 0, ST_MAN_OFF,  1'b0);
        add_step(REQ_ON,        1'b0, 15'd0,    1, 1, ST_MAN_ON,   1'b1);
        add_step(REQ_AUTO,      1'b0, 15'd0,    0, 0, ST_AUTO_OFF, 1'b0);
        add_step(REQ_MEAS,      1'b0, 15'd2500, 0, 0, ST_AUTO_OFF, 1'b0);
        add_step(REQ_ON,        1'b0, 15'd0,    0, 0, ST_AUTO_OFF, 1'b0);
        add_step(REQ_MEAS,      1'b0, -15'sd100, 0, 0, ST_AUTO_OFF, 1'b0);
        add_step(REQ_AUTO,      1'b0, 15'd0,    0, 0, ST_AUTO_OFF, 1'b0);
        add_step(REQ_AUTO,      1'b0, 15'd0,    0, 0, ST_AUTO_OFF, 1'b0);
        add_step(REQ_TOGGLE,    1'b0, 15'd0,    0, 0, ST_AUTO_OFF, 1'b0);
        add_step(REQ_TOGGLE,    1'b0, 15'd0,    0, 0, ST_AUTO_OFF, 1'b0);
        add_step(REQ_AUTO,      1'b1, 15'd0,    0, 0, ST_AUTO_OFF, 1'b0);
        add_step(REQ_MEAS,      1'b1, 15'd0,    0, 0, ST_AUTO_OFF, 1'b0);
        add_step(REQ_OFF,       1'b1, 15'd0,    0, 0, ST_AUTO_OFF, 1'b0);
        add_step(REQ_AUTO,      1'b1, 15'd0,    0, 0, ST_AUTO_OFF, 1'b0);
        add_step(REQ_TOGGLE,    1'b1, 15'd0,    0, 0, ST_AUTO_OFF, 1'b0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_steps[k])
            offer_request(directed_steps[k].req, directed_steps[k].chan, directed_steps[k].val,
                          directed_steps[k].typed, directed_steps[k].typed_has,
                          directed_steps[k].typed_status);
        settle();

        for (seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == 0)
                program_settings(15'h4000, 15'd0, 15'd0, 15'd0);
            else if (seg == 1)
                program_settings(15'h3FFF, 15'h7FFF, 15'h7FFF, 15'd1000);
            else
                program_settings(pick_setting(int'(VAL_LO), int'(TEMP_THR_HI)),
                                 pick_setting(0, int'(HYS_HI)),
                                 pick_setting(0, int'(HUM_THR_HI)),
                                 pick_setting(0, int'(HYS_HI)));
            case (seg / 2)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 88; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 88; end
                default: begin idle_pct = 15; stall_pct = 15; end
            endcase
            done = 0;
            while (done < SEGMENT_REQS) begin
                random_request(req, chan, val);
                offer_request(req, chan, val, 0, 0, none);
                done++;
            end
            settle();
        end

        // Every toggle changes the state code, so a held receiver backs up the input.
        idle_pct  = 0;
        stall_pct = 0;
        hold_reqs++;
        repeat (PRESSURE_REQS) begin
            chan = 1'($urandom_range(1));
            offer_request(REQ_TOGGLE, chan, 15'd0, 0, 0, none);
        end
        settle();

        $display("%0d requests accepted under %0d settings plus reset defaults",
                 accepted_count, settings_count);
        $display("%0d status changes checked, %0d errors", checked_count, error_count);
        if (error_count == 0 && pending_status.size() == 0) begin
            $display("dual_hysteresis_unit_control_top_tb: PASS");
        end else begin
            $display("dual_hysteresis_unit_control_top_tb: FAIL");
        end
        $finish;
    end

endmodule
